// ===== design/consistent_hash_ring_router_macros.svh =====
// assertion macros for the consistent hash ring router
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef CONSISTENT_HASH_RING_ROUTER_MACROS_SVH
`define CONSISTENT_HASH_RING_ROUTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define CHRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CHRR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHRR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/chrr_pkg.sv =====
// constants and the djb2 fold step for the consistent hash ring router
// no dependencies
`default_nettype none
package chrr_pkg;
	localparam int HASH_W = 32;
	localparam int CHAR_W = 7;
	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
	localparam logic [CHAR_W-1:0] CHAR_SHARP = 7'h23;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT0 = 7'h30;

	localparam int NODE_LIMIT_DEF = 16;
	localparam int VNODES_DEF = 3;
	localparam int RING_DEF = 360;

	// remainder unit: reciprocal multiply, then multiply back and subtract
	localparam int MOD_STEPS = 2;
	localparam int STEP_W = $clog2(MOD_STEPS);

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_ADD = 1'b1;

	localparam int NODE_INDEX_W = 4;
	localparam int KEY_POS_W = 9;

	function automatic logic [HASH_W-1:0] fold(input logic [HASH_W-1:0] h,
			input logic [HASH_W-1:0] c);
		return (h << 5) + h + c;
	endfunction
endpackage
`default_nettype wire

// ===== design/consistent_hash_ring_router.sv =====
// consistent hash ring router top level: djb2 hashing, vnode table, ring lookup
// depends on chrr_pkg, chrr_ram and consistent_hash_ring_router_macros.svh
//
//  channel   | handshake                 | words
//  ----------+---------------------------+------------------------------------------
//  input     | start high, busy low      | kind, char_byte, last
//  result    | done high for one cycle   | op_kind, success, node_index, key_position
//
// a byte without last leaves busy low; the block stays ready for the next
// after the last byte of a string the block is busy:
// lookup: the remainder steps, a read per stored vnode, then a drain; an empty table answers after the remainder
// add: a prep state, then a load and the remainder steps per vnode; a refused add answers at once
// the reciprocal remainder unit and the one-read ram scan set this
// no clearing pass after reset; the result side cannot stall
`default_nettype none
`include "consistent_hash_ring_router_macros.svh"
module consistent_hash_ring_router #(
	parameter int NODE_LIMIT = chrr_pkg::NODE_LIMIT_DEF,
	parameter int VNODES_PER_NODE = chrr_pkg::VNODES_DEF,
	parameter int RING_POSITIONS = chrr_pkg::RING_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [chrr_pkg::CHAR_W-1:0]       char_byte,
	input  logic                              last,
	output logic                              done,
	output logic                              op_kind,
	output logic                              success,
	output logic [chrr_pkg::NODE_INDEX_W-1:0] node_index,
	output logic [chrr_pkg::KEY_POS_W-1:0]    key_position
);
	localparam int SLOT_COUNT = NODE_LIMIT * VNODES_PER_NODE;
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int NODE_W = $clog2(NODE_LIMIT + 1);
	localparam int IDX_W = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;
	localparam int V_W = (VNODES_PER_NODE > 1) ? $clog2(VNODES_PER_NODE) : 1;
	localparam int POS_W = $clog2(RING_POSITIONS);
	localparam int PW1 = POS_W + 1;
	localparam int HW = chrr_pkg::HASH_W;
	localparam int NIW = chrr_pkg::NODE_INDEX_W;
	localparam int KPW = chrr_pkg::KEY_POS_W;
	localparam int MAG_W = HW + 1;
	localparam int MAG_SH = HW + POS_W;
	localparam int PROD_W = HW + MAG_W;
	localparam logic [PW1-1:0] MOD_M = PW1'(RING_POSITIONS);
	localparam logic [POS_W-1:0] MOD_LOW = POS_W'(RING_POSITIONS);
	// ceil(2^(HW+POS_W) / RING_POSITIONS), exact quotient for every hash value
	localparam logic [MAG_W-1:0] MOD_MAGIC = MAG_W'(((64'd1 << MAG_SH)
		+ 64'(RING_POSITIONS) - 64'd1) / 64'(RING_POSITIONS));
	localparam logic [chrr_pkg::STEP_W-1:0] STEP_LAST =
		chrr_pkg::STEP_W'(chrr_pkg::MOD_STEPS - 1);
	localparam logic [V_W-1:0] V_LAST = V_W'(VNODES_PER_NODE - 1);
	localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(NODE_LIMIT);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;

	logic [2:0]                   state_q;
	logic [HW-1:0]                hash_q;
	logic [HW-1:0]                sharp_q;
	logic [HW-1:0]                div_q;
	logic [POS_W-1:0]             quo_q;
	logic [chrr_pkg::STEP_W-1:0]  step_q;
	logic                         op_q;
	logic [NODE_W-1:0]            node_total_q;
	logic [CNT_W-1:0]             slot_next_q;
	logic [V_W-1:0]               vidx_q;
	logic [POS_W-1:0]             key_q;
	logic [CNT_W-1:0]             scan_addr_q;
	logic [IDX_W-1:0]             scan_node_q;
	logic [V_W-1:0]               scan_v_q;
	logic                         valid_s1;
	logic [IDX_W-1:0]             node_s1;
	logic                         valid_s2;
	logic [IDX_W-1:0]             node_s2;
	logic [PW1-1:0]               dist_s2;
	logic [PW1-1:0]               best_q;
	logic [IDX_W-1:0]             best_node_q;

	logic [HW-1:0]                hash_in;
	logic [PROD_W-1:0]            prod_c;
	logic [POS_W-1:0]             rem_next;
	logic [PW1-1:0]               dist_c;
	logic [PW1-1:0]               diff_c;
	logic [POS_W-1:0]             ram_rdata;
	logic                         ram_we;
	logic                         table_full;
	logic [IDX_W+NIW-1:0]         total_pad;
	logic [IDX_W+NIW-1:0]         best_pad;
	logic [POS_W+KPW-1:0]         rem_pad;
	logic [POS_W+KPW-1:0]         key_pad;

	assign busy = (state_q != S_IDLE);
	assign table_full = (node_total_q >= NODE_MAX);
	assign hash_in = (char_byte != '0)
		? chrr_pkg::fold(hash_q, HW'(char_byte)) : hash_q;
	assign total_pad = {{NIW{1'b0}}, node_total_q[IDX_W-1:0]};
	assign best_pad = {{NIW{1'b0}}, best_node_q};
	assign rem_pad = {{KPW{1'b0}}, rem_next};
	assign key_pad = {{KPW{1'b0}}, key_q};
	assign ram_we = (state_q == S_MOD) && (step_q == STEP_LAST) && (op_q == chrr_pkg::KIND_ADD);

	// quotient by reciprocal multiply, remainder from its low bits
	assign prod_c = {{MAG_W{1'b0}}, div_q} * {{HW{1'b0}}, MOD_MAGIC};
	assign rem_next = div_q[POS_W-1:0] - (quo_q * MOD_LOW);

	// clockwise distance from key to stored position
	always_comb begin
		diff_c = {1'b0, ram_rdata} - {1'b0, key_q};
		dist_c = diff_c[POS_W] ? (diff_c + MOD_M) : diff_c;
	end

	chrr_ram #(
		.WIDTH(POS_W),
		.DEPTH(SLOT_COUNT),
		.ADDR_W(SLOT_W)
	) u_pos_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_next_q[SLOT_W-1:0]),
		.wdata(rem_next),
		.raddr(scan_addr_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hash_q <= chrr_pkg::HASH_SEED;
			sharp_q <= '0;
			div_q <= '0;
			quo_q <= '0;
			step_q <= '0;
			op_q <= chrr_pkg::KIND_LOOKUP;
			node_total_q <= '0;
			slot_next_q <= '0;
			vidx_q <= '0;
			key_q <= '0;
			scan_addr_q <= '0;
			scan_node_q <= '0;
			scan_v_q <= '0;
			valid_s1 <= 1'b0;
			node_s1 <= '0;
			valid_s2 <= 1'b0;
			node_s2 <= '0;
			dist_s2 <= '0;
			best_q <= '0;
			best_node_q <= '0;
			done <= 1'b0;
			op_kind <= chrr_pkg::KIND_LOOKUP;
			success <= 1'b0;
			node_index <= '0;
			key_position <= '0;
		end else begin
			done <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= valid_s1;
			node_s2 <= node_s1;
			dist_s2 <= dist_c;
			if (valid_s2 && (dist_s2 < best_q)) begin
				best_q <= dist_s2;
				best_node_q <= node_s2;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (!last) begin
							hash_q <= hash_in;
						end else if (kind == chrr_pkg::KIND_ADD) begin
							op_q <= chrr_pkg::KIND_ADD;
							if (table_full) begin
								done <= 1'b1;
								op_kind <= chrr_pkg::KIND_ADD;
								success <= 1'b0;
								node_index <= '0;
								key_position <= '0;
								hash_q <= chrr_pkg::HASH_SEED;
							end else begin
								hash_q <= hash_in;
								state_q <= S_PREP;
							end
						end else begin
							op_q <= chrr_pkg::KIND_LOOKUP;
							div_q <= hash_in;
							step_q <= '0;
							hash_q <= chrr_pkg::HASH_SEED;
							state_q <= S_MOD;
						end
					end
				end
				S_PREP: begin
					sharp_q <= chrr_pkg::fold(hash_q, HW'(chrr_pkg::CHAR_SHARP));
					hash_q <= chrr_pkg::HASH_SEED;
					vidx_q <= '0;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					div_q <= chrr_pkg::fold(sharp_q,
						HW'(chrr_pkg::CHAR_DIGIT0) + HW'(vidx_q));
					step_q <= '0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					quo_q <= prod_c[MAG_SH +: POS_W];
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						if (op_q == chrr_pkg::KIND_ADD) begin
							slot_next_q <= slot_next_q + 1'b1;
							if (vidx_q == V_LAST) begin
								done <= 1'b1;
								op_kind <= chrr_pkg::KIND_ADD;
								success <= 1'b1;
								node_index <= total_pad[NIW-1:0];
								key_position <= '0;
								node_total_q <= node_total_q + 1'b1;
								state_q <= S_IDLE;
							end else begin
								vidx_q <= vidx_q + 1'b1;
								state_q <= S_LOAD;
							end
						end else begin
							key_q <= rem_next;
							if (node_total_q == '0) begin
								done <= 1'b1;
								op_kind <= chrr_pkg::KIND_LOOKUP;
								success <= 1'b0;
								node_index <= '0;
								key_position <= rem_pad[KPW-1:0];
								state_q <= S_IDLE;
							end else begin
								scan_addr_q <= '0;
								scan_node_q <= '0;
								scan_v_q <= '0;
								best_q <= MOD_M;
								best_node_q <= '0;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					valid_s1 <= 1'b1;
					node_s1 <= scan_node_q;
					scan_addr_q <= scan_addr_q + 1'b1;
					if (scan_v_q == V_LAST) begin
						scan_v_q <= '0;
						scan_node_q <= scan_node_q + 1'b1;
					end else begin
						scan_v_q <= scan_v_q + 1'b1;
					end
					if ((scan_addr_q + 1'b1) == slot_next_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						done <= 1'b1;
						op_kind <= chrr_pkg::KIND_LOOKUP;
						success <= 1'b1;
						node_index <= best_pad[NIW-1:0];
						key_position <= key_pad[KPW-1:0];
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CHRR_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`CHRR_ASSERT_IMP(a_total_bound, clk, arst_n, 1'b1, node_total_q <= NODE_MAX)
	`CHRR_ASSERT_IMP(a_add_count, clk, arst_n, done && op_kind && success, node_total_q == $past(node_total_q) + 1'b1)
	`CHRR_ASSERT_IMP(a_scan_read, clk, arst_n, valid_s1, state_q == S_SCAN || state_q == S_DRAIN)
	`CHRR_ASSERT_NXT(a_last_busy, clk, arst_n, start && !busy && last && !(kind && table_full), busy)
endmodule
`default_nettype wire

// ===== design/chrr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module chrr_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 48,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== tb/chrr_route_checker.sv =====
// route checker for the consistent hash ring router: predicts every answer from
// the accepted input words and compares it with the result words
// depends on chrr_pkg
module chrr_route_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              kind,
	input  logic [chrr_pkg::CHAR_W-1:0]       char_byte,
	input  logic                              last,
	input  logic                              done,
	input  logic                              op_kind,
	input  logic                              success,
	input  logic [chrr_pkg::NODE_INDEX_W-1:0] node_index,
	input  logic [chrr_pkg::KEY_POS_W-1:0]    key_position,
	output int                                mismatches,
	output int                                outstanding
);
	localparam int SLOTS = chrr_pkg::NODE_LIMIT_DEF * chrr_pkg::VNODES_DEF;

	typedef struct packed {
		logic                              op_kind;
		logic                              success;
		logic [chrr_pkg::NODE_INDEX_W-1:0] node_index;
		logic [chrr_pkg::KEY_POS_W-1:0]    key_position;
	} answer_t;

	answer_t                     pending_answers[$];
	logic [chrr_pkg::HASH_W-1:0] name_hash;
	int                          stored_nodes;
	int unsigned                 ring_pos[SLOTS];
	int                          err_cnt;
	answer_t                     got;
	answer_t                     want;

	function automatic logic [chrr_pkg::HASH_W-1:0] djb2_step(
			input logic [chrr_pkg::HASH_W-1:0] h,
			input logic [chrr_pkg::CHAR_W-1:0] c);
		return h * 33 + c;
	endfunction

	// predicts the answer to an add or a lookup; updates the node table on an add
	function automatic answer_t ring_answer(input logic op,
			input logic [chrr_pkg::HASH_W-1:0] h);
		answer_t     a;
		int unsigned key;
		int unsigned best;
		int unsigned span;
		int unsigned pos;
		int          owner;
		a = '0;
		a.op_kind = op;
		if (op == chrr_pkg::KIND_ADD) begin
			if (stored_nodes < chrr_pkg::NODE_LIMIT_DEF) begin
				for (int v = 0; v < chrr_pkg::VNODES_DEF; v++)
					ring_pos[stored_nodes * chrr_pkg::VNODES_DEF + v] =
						djb2_step(djb2_step(h, chrr_pkg::CHAR_SHARP),
						chrr_pkg::CHAR_DIGIT0 + chrr_pkg::CHAR_W'(v))
						% chrr_pkg::RING_DEF;
				a.success = 1'b1;
				a.node_index = chrr_pkg::NODE_INDEX_W'(stored_nodes);
				stored_nodes++;
			end
		end else begin
			key = h % chrr_pkg::RING_DEF;
			a.key_position = chrr_pkg::KEY_POS_W'(key);
			if (stored_nodes > 0) begin
				best = chrr_pkg::RING_DEF;
				owner = 0;
				for (int n = 0; n < stored_nodes; n++)
					for (int v = 0; v < chrr_pkg::VNODES_DEF; v++) begin
						pos = ring_pos[n * chrr_pkg::VNODES_DEF + v];
						span = (pos >= key) ? pos - key : chrr_pkg::RING_DEF - key + pos;
						if (span < best) begin
							best = span;
							owner = n;
						end
					end
				a.success = 1'b1;
				a.node_index = chrr_pkg::NODE_INDEX_W'(owner);
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_hash = chrr_pkg::HASH_SEED;
			stored_nodes = 0;
			err_cnt = 0;
			pending_answers.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (start && !busy) begin
				if (char_byte != '0)
					name_hash = djb2_step(name_hash, char_byte);
				if (last) begin
					pending_answers.push_back(ring_answer(kind, name_hash));
					name_hash = chrr_pkg::HASH_SEED;
				end
			end
			if (done) begin
				got = '{op_kind, success, node_index, key_position};
				if (pending_answers.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected word op_kind %0d success %0d node %0d key %0d",
						$time, got.op_kind, got.success, got.node_index, got.key_position);
				end else begin
					want = pending_answers.pop_front();
					if (got !== want) begin
						err_cnt++;
						$display({"%0t: mismatch expected op_kind %0d success %0d node %0d ",
							"key %0d, actual op_kind %0d success %0d node %0d key %0d"},
							$time, want.op_kind, want.success, want.node_index,
							want.key_position, got.op_kind, got.success, got.node_index,
							got.key_position);
					end
				end
			end
			mismatches <= err_cnt;
			outstanding <= pending_answers.size();
		end
	end
endmodule

// ===== tb/tb_consistent_hash_ring_router.sv =====
// testbench top for the consistent hash ring router: clock, reset, directed and
// random name and key strings with random gaps, and the verdict
// depends on chrr_pkg, consistent_hash_ring_router and chrr_route_checker
module tb_consistent_hash_ring_router;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WORD_GOAL = 1200;
	localparam int DRAIN_CYCLES = 80;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              kind = chrr_pkg::KIND_LOOKUP;
	logic [chrr_pkg::CHAR_W-1:0]       char_byte = '0;
	logic                              last = 1'b0;
	logic                              busy;
	logic                              done;
	logic                              op_kind;
	logic                              success;
	logic [chrr_pkg::NODE_INDEX_W-1:0] node_index;
	logic [chrr_pkg::KEY_POS_W-1:0]    key_position;
	int                                mismatches;
	int                                outstanding;
	int                                cycles = 0;
	int                                words_sent = 0;
	int                                gap_max = 5;

	always #2 clk = ~clk;

	consistent_hash_ring_router dut (.*);

	chrr_route_checker u_route_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("consistent_hash_ring_router test failed");
			$finish;
		end
	end

	task automatic send_word(input logic k, input logic [chrr_pkg::CHAR_W-1:0] c,
			input logic l);
		int gap;
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		char_byte <= c;
		last <= l;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	task automatic send_text(input logic k, input string s);
		byte b;
		for (int i = 0; i < s.len(); i++) begin
			b = s[i];
			send_word(k, b[chrr_pkg::CHAR_W-1:0], i == s.len() - 1);
		end
	endtask

	// zero bytes and stray kinds inside the string, the last byte sets the operation
	task automatic send_random_string(input logic k, input int len);
		logic [chrr_pkg::CHAR_W-1:0] c;
		logic                        kb;
		if (len == 0)
			send_word(k, '0, 1'b1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				c = '0;
			else if ($urandom_range(0, 1))
				c = chrr_pkg::CHAR_W'($urandom_range(1, 127));
			else
				c = chrr_pkg::CHAR_W'($urandom_range(97, 122));
			kb = ($urandom_range(0, 9) == 0 && i != len - 1) ? 1'($urandom_range(0, 1)) : k;
			send_word(kb, c, i == len - 1);
		end
	endtask

	initial begin
		int strings_done;
		logic k;
		int len;
		strings_done = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, empty strings, zero bytes, extremes, mixed kinds
		send_text(chrr_pkg::KIND_LOOKUP, "z");
		send_word(chrr_pkg::KIND_LOOKUP, '0, 1'b1);
		send_word(chrr_pkg::KIND_LOOKUP, 7'h6b, 1'b0);
		send_word(chrr_pkg::KIND_LOOKUP, '0, 1'b0);
		send_word(chrr_pkg::KIND_LOOKUP, 7'h71, 1'b1);
		send_word(chrr_pkg::KIND_ADD, '0, 1'b1);
		send_word(chrr_pkg::KIND_ADD, 7'h7f, 1'b0);
		send_word(chrr_pkg::KIND_ADD, 7'h01, 1'b1);
		send_word(chrr_pkg::KIND_LOOKUP, 7'h6e, 1'b0);
		send_word(chrr_pkg::KIND_ADD, 7'h6d, 1'b1);
		send_word(chrr_pkg::KIND_LOOKUP, 7'h7f, 1'b1);
		send_word(chrr_pkg::KIND_LOOKUP, 7'h01, 1'b1);
		send_word(chrr_pkg::KIND_LOOKUP, '0, 1'b1);
		send_text(chrr_pkg::KIND_ADD, "edge-router");
		send_text(chrr_pkg::KIND_LOOKUP, "user:42");

		while (words_sent < WORD_GOAL) begin
			if (strings_done % 20 == 0)
				gap_max = $urandom_range(0, 1) ? 5 : 0;
			k = ($urandom_range(0, 7) == 0) ? chrr_pkg::KIND_ADD : chrr_pkg::KIND_LOOKUP;
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
			send_random_string(k, len);
			strings_done++;
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("consistent_hash_ring_router test passed");
		else
			$display("consistent_hash_ring_router test failed");
		$finish;
	end
endmodule
